/* rtl/assert_macros.svh */
// Assertion macros used by the sorted integer set top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/sis_pkg.sv */
// Types and constants for the sorted integer set.
`timescale 1ns / 1ps

package sis_pkg;

   localparam int unsigned KEY_WIDTH      = 32;
   localparam int unsigned FUNC_WIDTH     = 2;
   localparam int unsigned STATUS_WIDTH   = 2;
   localparam int unsigned POS_WIDTH      = 6;
   localparam int unsigned CNT_OUT_WIDTH  = 7;
   localparam int unsigned RSP_DATA_WIDTH = 16;

   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_FIND   = 2'd2
   } func_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK       = 2'd0,
      ST_DUP      = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic load;   // latch compare flags against the incoming key
      logic ins;    // shift up from the slot and store the key
      logic rem;    // shift down from the slot
   } cell_ctrl_type;

endpackage

/* rtl/sis_cell.sv */
// One storage cell of the sorted set: holds a key and compares it to the request.
`timescale 1ns / 1ps

module sis_cell #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned CNT_W = 7
) (
   input  logic                              clock,
   input  sis_pkg::cell_ctrl_type            ctrl,
   input  logic [sis_pkg::KEY_WIDTH-1:0]     cmp_key,
   input  logic [sis_pkg::KEY_WIDTH-1:0]     ins_key,
   input  logic [CNT_W-1:0]                  count,
   input  logic                              prev_lt,
   input  logic [sis_pkg::KEY_WIDTH-1:0]     prev_entry,
   input  logic [sis_pkg::KEY_WIDTH-1:0]     next_entry,
   output logic                              lt,
   output logic                              eq,
   output logic [sis_pkg::KEY_WIDTH-1:0]     entry
);
   import sis_pkg::*;

   logic                 occupied;
   logic                 lt_ff;
   logic                 eq_ff;
   logic [KEY_WIDTH-1:0] entry_ff;
   logic [KEY_WIDTH-1:0] entry_in;

   // Entries at or above the count are stale and never match.
   assign occupied = CNT_W'(INDEX) < count;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins && !lt_ff) begin
         entry_in = prev_lt ? ins_key : prev_entry;
      end else if (ctrl.rem && !lt_ff) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         lt_ff <= occupied && ($signed(entry_ff) < $signed(cmp_key));
         eq_ff <= occupied && (entry_ff == cmp_key);
      end
      entry_ff <= entry_in;
   end

   assign lt    = lt_ff;
   assign eq    = eq_ff;
   assign entry = entry_ff;

endmodule

/* rtl/sorted_integer_set.sv */
// Top level of the sorted integer set: a row of compare-and-shift cells.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Holds up to CAPACITY distinct signed 32-bit keys in ascending order, one key per
// cell. On acceptance every cell compares its key with the request key in parallel;
// once the response register is free or being drained, the row shifts up (insert)
// or down (remove) around the slot found and the response is registered. A new
// request is taken only after the previous one has updated, and the response
// register lets the next request enter while a response still waits. Insert into
// a full set answers full, an existing key answers duplicate, and remove or find
// of an absent key (or an unused operation code) answers not found; every error
// reports position 0 and leaves the set unchanged.
module sorted_integer_set #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sis_pkg::KEY_WIDTH-1:0]      req_tdata,   // [31:0] value
   input  logic [sis_pkg::FUNC_WIDTH-1:0]     req_tuser,   // [1:0] func
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sis_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,   // [5:0] position, [12:6] count
   output logic [sis_pkg::STATUS_WIDTH-1:0]   rsp_tuser    // [1:0] status
);
   import sis_pkg::*;

   localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

   cell_ctrl_type          ctrl;
   logic                   cmp_ff;
   logic [FUNC_WIDTH-1:0]  func_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   rsp_valid_ff;
   logic [STATUS_WIDTH-1:0] rsp_status_ff;
   logic [POS_WIDTH-1:0]   rsp_pos_ff;
   logic [CNT_OUT_WIDTH-1:0] rsp_count_ff;
   logic                   accept;
   logic                   update;
   logic                   full;
   logic                   found;
   logic                   do_ins;
   logic                   do_rem;
   status_type             status_in;
   logic [IDX_W-1:0]       slot;
   logic [IDX_W-1:0]       pos_in;

   logic [CAPACITY-1:0]    lt_vec;
   logic [CAPACITY-1:0]    eq_vec;
   logic [CAPACITY-1:0]    bound_vec;
   logic [KEY_WIDTH-1:0]   entry_arr [CAPACITY];

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !cmp_ff;
   assign update     = cmp_ff && (!rsp_valid_ff || rsp_tready);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                 prev_lt;
      logic [KEY_WIDTH-1:0] prev_entry;
      logic [KEY_WIDTH-1:0] next_entry;

      if (i == 0) begin : g_first
         assign prev_lt    = 1'b1;
         assign prev_entry = key_ff;
      end else begin : g_mid
         assign prev_lt    = lt_vec[i-1];
         assign prev_entry = entry_arr[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_entry = entry_arr[i];
      end else begin : g_body
         assign next_entry = entry_arr[i+1];
      end

      // The slot is the first cell whose key is not below the request key.
      assign bound_vec[i] = !lt_vec[i] && prev_lt;

      sis_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cmp_key    (req_tdata),
         .ins_key    (key_ff),
         .count      (count_ff),
         .prev_lt    (prev_lt),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .lt         (lt_vec[i]),
         .eq         (eq_vec[i]),
         .entry      (entry_arr[i])
      );
   end

   // One-hot slot to binary index.
   always_comb begin
      slot = '0;
      for (int unsigned i = 0; i < CAPACITY; i++) begin
         if (bound_vec[i]) begin
            slot = slot | IDX_W'(i);
         end
      end
   end

   assign full  = count_ff == CNT_W'(CAPACITY);
   assign found = |eq_vec;

   always_comb begin
      status_in = ST_NOTFOUND;
      pos_in    = '0;
      do_ins    = 1'b0;
      do_rem    = 1'b0;
      count_in  = count_ff;
      unique case (func_ff)
         FUNC_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else if (found) begin
               status_in = ST_DUP;
            end else begin
               status_in = ST_OK;
               pos_in    = slot;
               do_ins    = 1'b1;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         FUNC_REMOVE: begin
            if (found) begin
               status_in = ST_OK;
               pos_in    = slot;
               do_rem    = 1'b1;
               count_in  = count_ff - CNT_W'(1);
            end
         end
         FUNC_FIND: begin
            if (found) begin
               status_in = ST_OK;
               pos_in    = slot;
            end
         end
         default: begin
            status_in = ST_NOTFOUND;
         end
      endcase
   end

   assign ctrl.load = accept;
   assign ctrl.ins  = update && do_ins;
   assign ctrl.rem  = update && do_rem;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            cmp_ff <= 1'b1;
         end else if (update) begin
            cmp_ff <= 1'b0;
         end
         if (update) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_tuser;
         key_ff  <= req_tdata;
      end
      if (update) begin
         rsp_status_ff <= status_in;
         rsp_pos_ff    <= POS_WIDTH'(pos_in);
         rsp_count_ff  <= CNT_OUT_WIDTH'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - CNT_OUT_WIDTH - POS_WIDTH){1'b0}},
                        rsp_count_ff, rsp_pos_ff};

   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(CAPACITY),
                 "count exceeds capacity")
   `ASSERT_CLK(a_one_in_flight, clock, reset, accept |=> !req_tready,
               "second transaction accepted before update")
   `ASSERT_CLK(a_ins_grows, clock, reset, (update && do_ins) |=>
               (count_ff == $past(count_ff) + CNT_W'(1)), "insert did not grow count")
   `ASSERT_CLK(a_err_pos_zero, clock, reset,
               (rsp_tvalid && (rsp_tuser != ST_OK)) |-> (rsp_tdata[POS_WIDTH-1:0] == '0),
               "error response with nonzero position")

endmodule
